### rtl/mfc_pkg.sv
// Shared widths, register codes and the queue item type of the forecast combiner.
package mfc_pkg;

  // Source count and field widths
  localparam int unsigned NUM_SOURCES_DEF = 4;
  localparam int unsigned MAX_SRC         = 4;
  localparam int unsigned VAL_W           = 32;
  localparam int unsigned W_W             = 16;
  localparam int unsigned MSK_W           = 4;
  localparam int unsigned CNT_W           = 3;
  localparam int unsigned PROD_W          = 49;
  localparam int unsigned SUM_W           = 34;
  localparam int unsigned NUM_W           = 51;
  localparam int unsigned DEN_W           = 18;
  localparam int unsigned MAG_W           = 51;
  localparam int unsigned QUO_W           = 33;
  localparam int unsigned QDEPTH_DEF      = 4;

  // Configuration port
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned CDAT_W = 16;

  localparam logic [CIDX_W-1:0] CFG_MODE    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_WEIGHT0 = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_WEIGHT1 = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_WEIGHT2 = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_WEIGHT3 = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_CUT     = 3'd5;

  // Combine modes; the spare code acts as weighted
  localparam logic [1:0] MODE_MEAN   = 2'd0;
  localparam logic [1:0] MODE_MEDIAN = 2'd1;

  localparam logic [W_W-1:0] WEIGHT_RST = 16'd16384;

  // One division job: rounded num/den, ok low when nothing contributed
  typedef struct packed {
    logic                    ok;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } qent_t;

endpackage

### rtl/mfc_if.sv
// Handshake channels of the forecast combiner: input items, results, register writes.
interface mfc_in_if;
  import mfc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] value_zero;
  logic signed [VAL_W-1:0] value_one;
  logic signed [VAL_W-1:0] value_two;
  logic signed [VAL_W-1:0] value_three;
  logic [MSK_W-1:0]        finite_mask;
  modport source (output valid, value_zero, value_one, value_two, value_three,
                  finite_mask, input ready);
  modport sink (input valid, value_zero, value_one, value_two, value_three,
                finite_mask, output ready);
endinterface

interface mfc_out_if;
  import mfc_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] combined_value;
  logic                    combined_valid;
  modport source (output valid, combined_value, combined_valid, input ready);
  modport sink (input valid, combined_value, combined_valid, output ready);
endinterface

interface mfc_cfg_if;
  import mfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/masked_forecast_combiner.sv
// Throughput: one item per cycle while the output is not stalled; the 33-stage divider
// takes a new job every cycle while it is not held by a waiting result.
// Front end (3 stages) and divider are split by a job queue, so each side stalls alone.
// Reset (rst, synchronous, active high) empties all stages and the queue, sets mean mode,
// all weights to 0.25 and the minimum-weight cut to zero.
module masked_forecast_combiner #(
  parameter int unsigned NUM_SOURCES = mfc_pkg::NUM_SOURCES_DEF,
  parameter int unsigned QUEUE_DEPTH = mfc_pkg::QDEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  mfc_cfg_if.sink   cfg,
  mfc_in_if.sink    src,
  mfc_out_if.source res
);
  import mfc_pkg::*;

  qent_t push_data, pop_data;
  logic  push, pop, full, empty;

  // Classify and build division jobs
  mfc_front #(.NUM_SRC(NUM_SOURCES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src       (src),
    .push_data (push_data),
    .push      (push),
    .full      (full)
  );

  // Job queue
  mfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // Divide, round and saturate
  mfc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_data (pop_data),
    .empty    (empty),
    .pop      (pop),
    .res      (res)
  );

endmodule

### rtl/mfc_front.sv
// Front end: registers, contributor masks, products, sort and division job setup.
module mfc_front #(
  parameter int unsigned NUM_SRC = mfc_pkg::NUM_SOURCES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  mfc_cfg_if.sink       cfg,
  mfc_in_if.sink        src,
  output mfc_pkg::qent_t push_data,
  output logic          push,
  input  logic          full
);
  import mfc_pkg::*;

  localparam logic [MSK_W-1:0] SRC_MASK = MSK_W'((1 << NUM_SRC) - 1);

  typedef struct packed {
    logic                    inv;
    logic signed [VAL_W-1:0] v;
  } key_t;

  // Configuration registers
  logic [1:0]     mode;
  logic [W_W-1:0] weight [MAX_SRC];
  logic [W_W-1:0] cut;

  // Stage 1
  logic                     s1_vld, s1_wtd, s1_med;
  logic [MSK_W-1:0]         s1_cm, s1_wm;
  logic signed [VAL_W-1:0]  s1_v [MAX_SRC];
  logic signed [PROD_W-1:0] s1_p [MAX_SRC];
  logic [W_W-1:0]           s1_w [MAX_SRC];

  // Stage 2
  logic                     s2_vld, s2_wtd, s2_med;
  logic signed [VAL_W-1:0]  s2_s [MAX_SRC];
  logic [CNT_W-1:0]         s2_n;
  logic signed [SUM_W-1:0]  s2_sum;
  logic signed [NUM_W-1:0]  s2_wsum;
  logic [DEN_W-1:0]         s2_wtot;

  // Stage 3
  logic  f3_vld;
  qent_t f3_ent;

  logic                    en;
  logic signed [VAL_W-1:0] vin [MAX_SRC];
  logic [MSK_W-1:0]        cm_c, wm_c;
  key_t                    k0 [MAX_SRC];
  key_t                    k1 [MAX_SRC];
  key_t                    k2 [MAX_SRC];
  key_t                    k3 [MAX_SRC];
  logic [CNT_W-1:0]        n_c;
  logic signed [SUM_W-1:0] sum_c;
  logic signed [NUM_W-1:0] wsum_c;
  logic [DEN_W-1:0]        wtot_c;
  qent_t                   ent_c;

  function automatic logic gt(key_t a, key_t b);
    logic r;
    if (a.inv != b.inv) r = a.inv;
    else r = (a.v > b.v);
    return r;
  endfunction

  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MEAN;
      cut  <= '0;
      for (int i = 0; i < MAX_SRC; i++) weight[i] <= WEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_MODE:    mode      <= cfg.data[1:0];
        CFG_WEIGHT0: weight[0] <= cfg.data;
        CFG_WEIGHT1: weight[1] <= cfg.data;
        CFG_WEIGHT2: weight[2] <= cfg.data;
        CFG_WEIGHT3: weight[3] <= cfg.data;
        CFG_CUT:     cut       <= cfg.data;
        default: ;
      endcase
    end
  end

  // Pipeline advances unless the last stage is blocked by a full queue
  assign en        = !(f3_vld && full);
  assign src.ready = en;
  assign push      = f3_vld && !full;
  assign push_data = f3_ent;

  // Contributor masks
  always_comb begin
    vin[0] = src.value_zero;
    vin[1] = src.value_one;
    vin[2] = src.value_two;
    vin[3] = src.value_three;
    cm_c   = src.finite_mask & SRC_MASK;
    for (int i = 0; i < MAX_SRC; i++)
      wm_c[i] = cm_c[i] && (weight[i] != '0) && (weight[i] >= cut);
  end

  // Stage 1: masks and weight products
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (en) s1_vld <= src.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_wtd <= (mode != MODE_MEAN) && (mode != MODE_MEDIAN);
      s1_med <= (mode == MODE_MEDIAN);
      s1_cm  <= cm_c;
      s1_wm  <= wm_c;
      for (int i = 0; i < MAX_SRC; i++) begin
        s1_v[i] <= vin[i];
        s1_w[i] <= weight[i];
        s1_p[i] <= PROD_W'($signed({1'b0, weight[i]}) * vin[i]);
      end
    end
  end

  // Sums and a four-input sorting network, non-contributors sink to the top
  always_comb begin
    n_c    = '0;
    sum_c  = '0;
    wsum_c = '0;
    wtot_c = '0;
    for (int i = 0; i < MAX_SRC; i++) begin
      k0[i].inv = !s1_cm[i];
      k0[i].v   = s1_v[i];
      if (s1_cm[i]) begin
        n_c   = n_c + CNT_W'(1);
        sum_c = sum_c + SUM_W'(s1_v[i]);
      end
      if (s1_wm[i]) begin
        wsum_c = wsum_c + NUM_W'(s1_p[i]);
        wtot_c = wtot_c + DEN_W'(s1_w[i]);
      end
    end
    k1 = k0;
    if (gt(k0[0], k0[1])) begin k1[0] = k0[1]; k1[1] = k0[0]; end
    if (gt(k0[2], k0[3])) begin k1[2] = k0[3]; k1[3] = k0[2]; end
    k2 = k1;
    if (gt(k1[0], k1[2])) begin k2[0] = k1[2]; k2[2] = k1[0]; end
    if (gt(k1[1], k1[3])) begin k2[1] = k1[3]; k2[3] = k1[1]; end
    k3 = k2;
    if (gt(k2[1], k2[2])) begin k3[1] = k2[2]; k3[2] = k2[1]; end
  end

  // Stage 2
  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (en) s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_wtd  <= s1_wtd;
      s2_med  <= s1_med;
      s2_n    <= n_c;
      s2_sum  <= sum_c;
      s2_wsum <= wsum_c;
      s2_wtot <= wtot_c;
      for (int i = 0; i < MAX_SRC; i++) s2_s[i] <= k3[i].v;
    end
  end

  // Division job per mode
  always_comb begin
    ent_c.ok  = 1'b0;
    ent_c.num = '0;
    ent_c.den = DEN_W'(1);
    if (s2_wtd) begin
      if (s2_wtot != '0) begin
        ent_c.ok  = 1'b1;
        ent_c.num = s2_wsum;
        ent_c.den = s2_wtot;
      end
    end else if (s2_n != '0) begin
      ent_c.ok = 1'b1;
      if (s2_med) begin
        case (s2_n)
          CNT_W'(1): ent_c.num = NUM_W'(s2_s[0]);
          CNT_W'(2): begin
            ent_c.num = NUM_W'(s2_s[0]) + NUM_W'(s2_s[1]);
            ent_c.den = DEN_W'(2);
          end
          CNT_W'(3): ent_c.num = NUM_W'(s2_s[1]);
          CNT_W'(4): begin
            ent_c.num = NUM_W'(s2_s[1]) + NUM_W'(s2_s[2]);
            ent_c.den = DEN_W'(2);
          end
          default: ent_c.num = '0;
        endcase
      end else begin
        ent_c.num = NUM_W'(s2_sum);
        ent_c.den = DEN_W'(s2_n);
      end
    end
  end

  // Stage 3: job waiting for the queue
  always_ff @(posedge clk) begin
    if (rst) f3_vld <= 1'b0;
    else if (en) f3_vld <= s2_vld;
  end

  always_ff @(posedge clk) begin
    if (en) f3_ent <= ent_c;
  end

endmodule

### rtl/mfc_queue.sv
// Small FIFO of division jobs between the front end and the divider.
module mfc_queue #(
  parameter int unsigned DEPTH = mfc_pkg::QDEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mfc_pkg::qent_t push_data,
  output logic           full,
  input  logic           pop,
  output mfc_pkg::qent_t pop_data,
  output logic           empty
);
  import mfc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

  qent_t              mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W_Q-1:0] count;

  assign full     = (count == CNT_W_Q'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop) count <= count + CNT_W_Q'(1);
      else if (pop && !push) count <= count - CNT_W_Q'(1);
    end
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) count <= CNT_W_Q'(DEPTH))
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> count == $past(count) + CNT_W_Q'(1))
    else $error("queue count not tracking pushes");
`endif

endmodule

### rtl/mfc_back.sv
// Back end: pipelined restoring divider with rounding, saturation and result register.
module mfc_back (
  input  logic           clk,
  input  logic           rst,
  input  mfc_pkg::qent_t pop_data,
  input  logic           empty,
  output logic           pop,
  mfc_out_if.source      res
);
  import mfc_pkg::*;

  localparam logic signed [QUO_W:0] SAT_MAX = (QUO_W + 1)'(32'sh7FFFFFFF);
  localparam logic signed [QUO_W:0] SAT_MIN = -(QUO_W + 1)'(33'sh080000000);

  logic                   en;
  logic [MAG_W-1:0]       mag;
  logic                   d_vld [QUO_W+1];
  logic [MAG_W-1:0]       d_rem [QUO_W+1];
  logic [QUO_W-1:0]       d_q   [QUO_W+1];
  logic [DEN_W-1:0]       d_den [QUO_W+1];
  logic                   d_neg [QUO_W+1];
  logic                   d_ok  [QUO_W+1];
  logic signed [QUO_W:0]  sq;
  logic signed [VAL_W-1:0] sat_c;

  // Whole divider pipeline holds while a result waits
  assign en  = !res.valid || res.ready;
  assign pop = en && !empty;

  assign mag = pop_data.num[NUM_W-1] ? MAG_W'(-pop_data.num) : MAG_W'(pop_data.num);

  // Load: magnitude plus half the divisor gives round half away from zero
  always_ff @(posedge clk) begin
    if (rst) d_vld[0] <= 1'b0;
    else if (en) d_vld[0] <= pop;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_rem[0] <= mag + MAG_W'(pop_data.den >> 1);
      d_q[0]   <= '0;
      d_den[0] <= pop_data.den;
      d_neg[0] <= pop_data.num[NUM_W-1];
      d_ok[0]  <= pop_data.ok;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar i = 1; i <= QUO_W; i++) begin : g_div
    localparam int unsigned B = QUO_W - i;
    logic [MAG_W-1:0] trial;
    assign trial = MAG_W'(d_den[i-1]) << B;

    always_ff @(posedge clk) begin
      if (rst) d_vld[i] <= 1'b0;
      else if (en) d_vld[i] <= d_vld[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_den[i] <= d_den[i-1];
        d_neg[i] <= d_neg[i-1];
        d_ok[i]  <= d_ok[i-1];
        if (d_rem[i-1] >= trial) begin
          d_rem[i] <= d_rem[i-1] - trial;
          d_q[i]   <= d_q[i-1] | (QUO_W'(1) << B);
        end else begin
          d_rem[i] <= d_rem[i-1];
          d_q[i]   <= d_q[i-1];
        end
      end
    end
  end

  // Sign and saturation
  always_comb begin
    sq = d_neg[QUO_W] ? -$signed({1'b0, d_q[QUO_W]}) : $signed({1'b0, d_q[QUO_W]});
    if (sq > SAT_MAX) sat_c = VAL_W'(SAT_MAX);
    else if (sq < SAT_MIN) sat_c = VAL_W'(SAT_MIN);
    else sat_c = VAL_W'(sq);
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (en) res.valid <= d_vld[QUO_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.combined_value <= d_ok[QUO_W] ? sat_c : '0;
      res.combined_valid <= d_ok[QUO_W];
    end
  end

endmodule

### verif/mfc_checker.sv
// Checker for the forecast combiner: predicts each result and compares it with the output.
module mfc_checker (
  input  logic     clk,
  input  logic     rst,
  mfc_cfg_if.sink  cfg,
  mfc_in_if.sink   src,
  mfc_out_if.sink  res,
  output int       fail_count,
  output int       pending
);
  import mfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    ok;
  } forecast_t;

  // Shadow copy of the registers
  logic [1:0]     mode_q;
  logic [W_W-1:0] weight_q [MAX_SRC];
  logic [W_W-1:0] cut_q;

  forecast_t forecast_q [$];

  // Rounded division, nearest with ties away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint quo;
    mag = (num < 0) ? -num : num;
    quo = (mag + den / 2) / den;
    return (num < 0) ? -quo : quo;
  endfunction

  // Expected combined value for one horizon step
  function automatic forecast_t combine(logic signed [VAL_W-1:0] vals [MAX_SRC],
                                        logic [MSK_W-1:0] mask);
    longint    sorted [MAX_SRC];
    longint    v;
    longint    acc;
    longint    wtot;
    longint    r;
    int        n;
    int        j;
    forecast_t f;
    n = 0;
    acc = 0;
    wtot = 0;
    r = 0;
    f.ok = 1'b0;
    if (mode_q == MODE_MEAN || mode_q == MODE_MEDIAN) begin
      for (int i = 0; i < MAX_SRC; i++) begin
        if (mask[i]) begin
          v = vals[i];
          j = n;
          while (j > 0 && sorted[j-1] > v) begin
            sorted[j] = sorted[j-1];
            j--;
          end
          sorted[j] = v;
          n++;
        end
      end
      if (n > 0) begin
        f.ok = 1'b1;
        if (mode_q == MODE_MEAN) begin
          for (int i = 0; i < n; i++) acc += sorted[i];
          r = round_div(acc, n);
        end else if (n % 2 == 1) begin
          r = sorted[n/2];
        end else begin
          r = round_div(sorted[n/2-1] + sorted[n/2], 2);
        end
      end
    end else begin
      // weighted: cut only applies to nonzero weights
      for (int i = 0; i < MAX_SRC; i++) begin
        if (mask[i] && weight_q[i] != 0 && weight_q[i] >= cut_q) begin
          acc += longint'(weight_q[i]) * longint'(vals[i]);
          wtot += weight_q[i];
        end
      end
      if (wtot > 0) begin
        f.ok = 1'b1;
        r = round_div(acc, wtot);
      end
    end
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    f.value = f.ok ? r[VAL_W-1:0] : '0;
    return f;
  endfunction

  always @(posedge clk) begin
    logic signed [VAL_W-1:0] vals [MAX_SRC];
    forecast_t exp_f;
    if (rst) begin
      mode_q <= MODE_MEAN;
      for (int i = 0; i < MAX_SRC; i++) weight_q[i] <= WEIGHT_RST;
      cut_q <= '0;
      forecast_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MODE:    mode_q <= cfg.data[1:0];
          CFG_WEIGHT0: weight_q[0] <= cfg.data;
          CFG_WEIGHT1: weight_q[1] <= cfg.data;
          CFG_WEIGHT2: weight_q[2] <= cfg.data;
          CFG_WEIGHT3: weight_q[3] <= cfg.data;
          CFG_CUT:     cut_q <= cfg.data;
          default: ;
        endcase
      end
      // accepted input item
      if (src.valid && src.ready) begin
        vals[0] = src.value_zero;
        vals[1] = src.value_one;
        vals[2] = src.value_two;
        vals[3] = src.value_three;
        forecast_q.insert(forecast_q.size(), combine(vals, src.finite_mask));
      end
      // accepted result item
      if (res.valid && res.ready) begin
        if (forecast_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d ok=%0b", $time,
                   res.combined_value, res.combined_valid);
          fail_count <= fail_count + 1;
        end else begin
          exp_f = forecast_q.pop_front();
          if (exp_f.value !== res.combined_value || exp_f.ok !== res.combined_valid) begin
            $display("%0t: mismatch expected value=%0d ok=%0b actual value=%0d ok=%0b",
                     $time, exp_f.value, exp_f.ok, res.combined_value, res.combined_valid);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= forecast_q.size();
    end
  end
endmodule

### verif/masked_forecast_combiner_tb.sv
// Stimulus, idling phases and verdict for the forecast combiner testbench.
module masked_forecast_combiner_tb;
  import mfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  bit   hold_off = 1'b0;
  int   idle_cycles = 0;
  bit   timed_out = 1'b0;

  mfc_cfg_if cfg ();
  mfc_in_if  src ();
  mfc_out_if res ();

  masked_forecast_combiner DUT (.clk(clk), .rst(rst), .cfg(cfg), .src(src), .res(res));
  mfc_checker checker_i (.clk(clk), .rst(rst), .cfg(cfg), .src(src), .res(res),
                         .fail_count(fail_count), .pending(pending));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    src.valid = 1'b0;
    src.value_zero = '0;
    src.value_one = '0;
    src.value_two = '0;
    src.value_three = '0;
    src.finite_mask = '0;
    res.ready = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= !hold_off && ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if ((src.valid && src.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
  end

  always @(posedge clk) begin
    if (timed_out) begin
      $display("masked_forecast_combiner test failed");
      $finish;
    end
  end

  // One register write, then the channel is left quiet before the task returns
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Valid stays high after acceptance so the next item can follow at once
  task automatic send_step(logic signed [VAL_W-1:0] v0, v1, v2, v3,
                           logic [MSK_W-1:0] mask);
    while ($urandom_range(99) < src_idle_pct) begin
      src.valid <= 1'b0;
      @(posedge clk);
    end
    src.valid <= 1'b1;
    src.value_zero <= v0;
    src.value_one <= v1;
    src.value_two <= v2;
    src.value_three <= v3;
    src.finite_mask <= mask;
    do @(posedge clk); while (!src.ready);
  endtask

  // Drain every expected result, then let the pipeline settle
  task automatic drain();
    src.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF - $urandom_range(3);
      1: return 32'h8000_0000 + $urandom_range(3);
      2: return $urandom_range(131072) - 65536;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_steps(int count);
    for (int i = 0; i < count; i++) begin
      send_step(rand_value(), rand_value(), rand_value(), rand_value(),
                $urandom_range(15));
      // broken stretches: send valid low for a cycle now and then
      if ($urandom_range(30) == 0) begin
        src.valid <= 1'b0;
        @(posedge clk);
      end
    end
    src.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_config(logic [1:0] mode);
    write_reg(CFG_MODE, {14'd0, mode});
    write_reg(CFG_WEIGHT0, $urandom_range(3) == 0 ? 16'd0 : 16'($urandom()));
    write_reg(CFG_WEIGHT1, 16'($urandom()));
    write_reg(CFG_WEIGHT2, $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom()));
    write_reg(CFG_WEIGHT3, 16'($urandom_range(1, 200)));
    write_reg(CFG_CUT, $urandom_range(2) == 0 ? 16'd0 : 16'($urandom_range(40000)));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default mean, extremes, empty mask, masks 0, 3, 6, 9, 12 and 15 in median
    send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'hF);
    send_step(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4'hF);
    send_step(32'd1, 32'd2, 32'd0, 32'd0, 4'h3);
    send_step(-32'sd1, -32'sd2, 32'd0, 32'd0, 4'h3);
    send_step(32'd5, 32'd6, 32'd7, 32'd8, 4'h0);
    drain();
    write_reg(CFG_MODE, {14'd0, MODE_MEDIAN});
    for (int m = 0; m < 16; m += 3)
      send_step(32'd40, -32'sd7, 32'h7FFF_FFFF, 32'h8000_0001, 4'(m));
    send_step(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd0, 32'd0, 4'h3);
    drain();
    // weighted with reset weights, full weights, a cut, and the spare mode
    write_reg(CFG_MODE, 16'd2);
    send_step(32'h7FFF_FFFF, 32'h8000_0000, 32'd3, -32'sd3, 4'hF);
    drain();
    write_reg(CFG_WEIGHT0, 16'hFFFF);
    write_reg(CFG_WEIGHT1, 16'd0);
    write_reg(CFG_WEIGHT2, 16'd1);
    write_reg(CFG_WEIGHT3, 16'd100);
    write_reg(CFG_CUT, 16'd50);
    send_step(32'h7FFF_FFFF, 32'd9, 32'd9, 32'h8000_0000, 4'hF);
    send_step(32'd1, 32'd9, 32'd9, 32'd9, 4'h6);
    drain();
    write_reg(CFG_MODE, 16'd3);
    write_reg(CFG_CUT, 16'hFFFF);
    send_step(32'd100, 32'd1, 32'd1, 32'd1, 4'hF);
    send_step(32'd100, 32'd1, 32'd1, 32'd1, 4'hE);
    drain();

    // Random phases over idling settings and register settings
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 47; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 47; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase
      random_config(2'(ph % 4));
      if (ph == 5) begin
        // long hold-off at the receiver while items keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (200) @(posedge clk);
            hold_off = 1'b0;
          end
          random_steps(83);
        join
      end else begin
        random_steps(83);
      end
      drain();
    end

    src_idle_pct = 0;
    snk_stall_pct = 0;
    drain();
    if (fail_count == 0)
      $display("masked_forecast_combiner test passed");
    else
      $display("masked_forecast_combiner test failed");
    $finish;
  end
endmodule

### masked_forecast_combiner.f
rtl/mfc_pkg.sv
rtl/mfc_if.sv
rtl/mfc_front.sv
rtl/mfc_queue.sv
rtl/mfc_back.sv
rtl/masked_forecast_combiner.sv
verif/mfc_checker.sv
verif/masked_forecast_combiner_tb.sv
